[src/lcd4_pkg.sv]
// Shared types, codes and constants for the 4-bit character LCD interface.
// Used by lcd4_front, lcd4_back and char_lcd_4bit_interface. No dependencies.
package lcd4_pkg;

  localparam int unsigned SHORT_W  = 10;
  localparam int unsigned LONG_W   = 18;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = LONG_W;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_INIT = 2'd3
  } op_t;

  localparam logic [CFG_AW-1:0] CFG_NIBBLE_GAP  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_WRITE_PAUSE = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_CHAR_PAUSE  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_POWER_WAIT  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_INIT_DONE   = 3'd4;

  localparam logic [SHORT_W-1:0] NIBBLE_GAP_RST  = 10'd100;
  localparam logic [SHORT_W-1:0] WRITE_PAUSE_RST = 10'd50;
  localparam logic [LONG_W-1:0]  CHAR_PAUSE_RST  = 18'd200000;
  localparam logic [LONG_W-1:0]  POWER_WAIT_RST  = 18'd40000;
  localparam logic [LONG_W-1:0]  INIT_DONE_RST   = 18'd50000;

  localparam logic [LONG_W-1:0] WAIT_5000 = 18'd5000;
  localparam logic [LONG_W-1:0] WAIT_100  = 18'd100;
  localparam logic [LONG_W-1:0] WAIT_50   = 18'd50;
  localparam logic [LONG_W-1:0] WAIT_ONE  = 18'd1;

  localparam logic [3:0] NIB_THREE = 4'h3;
  localparam logic [3:0] NIB_TWO   = 4'h2;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_PWAIT  = 5'd1;
  localparam logic [4:0] PH_N1_SET = 5'd2;
  localparam logic [4:0] PH_N1_EN  = 5'd3;
  localparam logic [4:0] PH_N1_GAP = 5'd4;
  localparam logic [4:0] PH_W5000  = 5'd5;
  localparam logic [4:0] PH_N2_SET = 5'd6;
  localparam logic [4:0] PH_N2_EN  = 5'd7;
  localparam logic [4:0] PH_N2_GAP = 5'd8;
  localparam logic [4:0] PH_W100   = 5'd9;
  localparam logic [4:0] PH_N3_SET = 5'd10;
  localparam logic [4:0] PH_N3_EN  = 5'd11;
  localparam logic [4:0] PH_N3_GAP = 5'd12;
  localparam logic [4:0] PH_W50A   = 5'd13;
  localparam logic [4:0] PH_N4_SET = 5'd14;
  localparam logic [4:0] PH_N4_EN  = 5'd15;
  localparam logic [4:0] PH_N4_GAP = 5'd16;
  localparam logic [4:0] PH_W50B   = 5'd17;
  localparam logic [4:0] PH_PDONE  = 5'd18;
  localparam logic [4:0] PH_HI_SET = 5'd19;
  localparam logic [4:0] PH_HI_EN  = 5'd20;
  localparam logic [4:0] PH_HI_GAP = 5'd21;
  localparam logic [4:0] PH_LO_SET = 5'd22;
  localparam logic [4:0] PH_LO_EN  = 5'd23;
  localparam logic [4:0] PH_LO_GAP = 5'd24;
  localparam logic [4:0] PH_CHARP  = 5'd25;
  localparam logic [4:0] PH_WRITEP = 5'd26;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic       long_pause;
  } in_item_t;

  typedef struct packed {
    logic       rs_level;
    logic       en_level;
    logic [3:0] bus_nibble;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    op_t        kind;
    logic [7:0] value;
    logic       pause;
  } req_t;

endpackage

[src/char_lcd_4bit_interface.sv]
// Top level of the 4-bit character LCD interface: request queue plus sequencer.
// Depends on lcd4_pkg, lcd4_front and lcd4_back.
// Each input item is registered in the queue, then its result in the result register.
// Throughput: 1 item per cycle while out_stall is low; the sequencer updates its state once per item.
// Reset: synchronous, active low; clears queue, sequencer, pins, and loads
// default timing registers.
module char_lcd_4bit_interface #(
  parameter int unsigned QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lcd4_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lcd4_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lcd4_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lcd4_pkg::out_item_t         out_data
);

  logic           q_valid;
  logic           q_pop;
  lcd4_pkg::req_t q_item;

  lcd4_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lcd4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/lcd4_front.sv]
// Front end: accepts input items, classifies the op and queues requests.
// Depends on lcd4_pkg.
module lcd4_front #(
  parameter int unsigned QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcd4_pkg::in_item_t in_data,
  output logic              q_valid,
  output lcd4_pkg::req_t    q_item,
  input  logic              q_pop
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  lcd4_pkg::req_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  lcd4_pkg::req_t        req;
  logic                  push;

  assign in_stall = (count_r == CNT_FULL);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    req.kind  = lcd4_pkg::op_t'(in_data.op);
    req.value = in_data.value;
    req.pause = (req.kind == lcd4_pkg::OP_DATA) && in_data.long_pause;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= req;
    end
  end

endmodule

[src/lcd4_back.sv]
// Back end: pin sequencer, wait counter, timing registers and result register.
// Depends on lcd4_pkg; fed by lcd4_front.
module lcd4_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcd4_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [lcd4_pkg::CFG_DW-1:0]     cfg_wdata,
  input  logic                            q_valid,
  input  lcd4_pkg::req_t                  q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lcd4_pkg::out_item_t             out_data
);

  logic [lcd4_pkg::SHORT_W-1:0] gap_r, wpause_r;
  logic [lcd4_pkg::LONG_W-1:0]  cpause_r, pwait_r, idone_r;

  logic [4:0]  phase_r, phase_nxt;
  logic [lcd4_pkg::LONG_W-1:0] wait_r, wait_nxt, wait_dec;
  logic [7:0]  held_r, held_nxt;
  logic        pause_r, pause_nxt;
  logic        rs_r, rs_nxt;
  logic        en_r, en_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic        rej;

  logic        do_enter;
  logic [4:0]  start_p, p;
  logic        is_gap;

  logic                out_valid_r, out_valid_nxt;
  lcd4_pkg::out_item_t out_data_r, out_data_nxt;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wait_dec  = (wait_r != '0) ? wait_r - 1'b1 : '0;

  always_comb begin
    held_nxt  = held_r;
    pause_nxt = pause_r;
    rs_nxt    = rs_r;
    en_nxt    = en_r;
    nib_nxt   = nib_r;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    rej       = 1'b0;
    do_enter  = 1'b0;
    start_p   = lcd4_pkg::PH_IDLE;

    if (q_item.kind == lcd4_pkg::OP_TICK) begin
      if (phase_r != lcd4_pkg::PH_IDLE) begin
        wait_nxt = wait_dec;
        if (wait_dec == '0) begin
          do_enter = 1'b1;
          if (phase_r == lcd4_pkg::PH_PDONE || phase_r >= lcd4_pkg::PH_WRITEP) begin
            start_p = lcd4_pkg::PH_IDLE;
          end else begin
            start_p = phase_r + 1'b1;
          end
        end
      end
    end else if (phase_r != lcd4_pkg::PH_IDLE) begin
      rej = 1'b1;
    end else if (q_item.kind == lcd4_pkg::OP_INIT) begin
      rs_nxt    = 1'b0;
      en_nxt    = 1'b0;
      nib_nxt   = 4'h0;
      pause_nxt = 1'b0;
      do_enter  = 1'b1;
      start_p   = lcd4_pkg::PH_PWAIT;
    end else begin
      held_nxt  = q_item.value;
      rs_nxt    = (q_item.kind == lcd4_pkg::OP_DATA);
      pause_nxt = q_item.pause;
      do_enter  = 1'b1;
      start_p   = lcd4_pkg::PH_HI_SET;
    end

    // skip zero-length waits
    p = start_p;
    is_gap = (p == lcd4_pkg::PH_N1_GAP) || (p == lcd4_pkg::PH_N2_GAP) ||
             (p == lcd4_pkg::PH_N3_GAP) || (p == lcd4_pkg::PH_N4_GAP) ||
             (p == lcd4_pkg::PH_HI_GAP) || (p == lcd4_pkg::PH_LO_GAP);
    if ((p == lcd4_pkg::PH_PWAIT && pwait_r == '0) || (is_gap && gap_r == '0)) begin
      p = p + 1'b1;
    end
    if (p == lcd4_pkg::PH_PDONE && idone_r == '0) begin
      p = lcd4_pkg::PH_IDLE;
    end
    if (p == lcd4_pkg::PH_CHARP) begin
      if (do_enter) begin
        rs_nxt = 1'b0;
      end
      if (!pause_nxt || cpause_r == '0) begin
        p = lcd4_pkg::PH_WRITEP;
      end
    end
    if (p == lcd4_pkg::PH_WRITEP && wpause_r == '0) begin
      p = lcd4_pkg::PH_IDLE;
    end

    if (do_enter) begin
      phase_nxt = p;
      en_nxt = (p == lcd4_pkg::PH_N1_EN) || (p == lcd4_pkg::PH_N2_EN) ||
               (p == lcd4_pkg::PH_N3_EN) || (p == lcd4_pkg::PH_N4_EN) ||
               (p == lcd4_pkg::PH_HI_EN) || (p == lcd4_pkg::PH_LO_EN);
      case (p)
        lcd4_pkg::PH_N1_SET, lcd4_pkg::PH_N2_SET,
        lcd4_pkg::PH_N3_SET: nib_nxt = lcd4_pkg::NIB_THREE;
        lcd4_pkg::PH_N4_SET: nib_nxt = lcd4_pkg::NIB_TWO;
        lcd4_pkg::PH_HI_SET: nib_nxt = held_nxt[7:4];
        lcd4_pkg::PH_LO_SET: nib_nxt = held_nxt[3:0];
        default:             nib_nxt = nib_nxt;
      endcase
      case (p)
        lcd4_pkg::PH_IDLE:   wait_nxt = '0;
        lcd4_pkg::PH_PWAIT:  wait_nxt = pwait_r;
        lcd4_pkg::PH_W5000:  wait_nxt = lcd4_pkg::WAIT_5000;
        lcd4_pkg::PH_W100:   wait_nxt = lcd4_pkg::WAIT_100;
        lcd4_pkg::PH_W50A,
        lcd4_pkg::PH_W50B:   wait_nxt = lcd4_pkg::WAIT_50;
        lcd4_pkg::PH_PDONE:  wait_nxt = idone_r;
        lcd4_pkg::PH_N1_GAP, lcd4_pkg::PH_N2_GAP, lcd4_pkg::PH_N3_GAP,
        lcd4_pkg::PH_N4_GAP, lcd4_pkg::PH_HI_GAP,
        lcd4_pkg::PH_LO_GAP: wait_nxt = {{(lcd4_pkg::LONG_W - lcd4_pkg::SHORT_W){1'b0}}, gap_r};
        lcd4_pkg::PH_CHARP:  wait_nxt = cpause_r;
        lcd4_pkg::PH_WRITEP: wait_nxt = {{(lcd4_pkg::LONG_W - lcd4_pkg::SHORT_W){1'b0}}, wpause_r};
        default:             wait_nxt = lcd4_pkg::WAIT_ONE;
      endcase
    end

    out_data_nxt.rs_level   = rs_nxt;
    out_data_nxt.en_level   = en_nxt;
    out_data_nxt.bus_nibble = nib_nxt;
    out_data_nxt.busy_res   = (phase_nxt != lcd4_pkg::PH_IDLE);
    out_data_nxt.rejected   = rej;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= lcd4_pkg::NIBBLE_GAP_RST;
      wpause_r    <= lcd4_pkg::WRITE_PAUSE_RST;
      cpause_r    <= lcd4_pkg::CHAR_PAUSE_RST;
      pwait_r     <= lcd4_pkg::POWER_WAIT_RST;
      idone_r     <= lcd4_pkg::INIT_DONE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        lcd4_pkg::CFG_NIBBLE_GAP:  gap_r    <= cfg_wdata[lcd4_pkg::SHORT_W-1:0];
        lcd4_pkg::CFG_WRITE_PAUSE: wpause_r <= cfg_wdata[lcd4_pkg::SHORT_W-1:0];
        lcd4_pkg::CFG_CHAR_PAUSE:  cpause_r <= cfg_wdata;
        lcd4_pkg::CFG_POWER_WAIT:  pwait_r  <= cfg_wdata;
        lcd4_pkg::CFG_INIT_DONE:   idone_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lcd4_pkg::PH_IDLE;
      wait_r      <= '0;
      held_r      <= '0;
      pause_r     <= 1'b0;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
        wait_r  <= wait_nxt;
        held_r  <= held_nxt;
        pause_r <= pause_nxt;
        rs_r    <= rs_nxt;
        en_r    <= en_nxt;
        nib_r   <= nib_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for char_lcd_4bit_interface: directed and random requests and ticks,
// with an in-bench pin forecast checked against every result.
// Depends on lcd4_pkg and the char_lcd_4bit_interface RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef logic [lcd4_pkg::CFG_AW-1:0] cfg_idx_t;
  typedef logic [lcd4_pkg::CFG_DW-1:0] cfg_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [lcd4_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [lcd4_pkg::CFG_DW-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  lcd4_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lcd4_pkg::out_item_t           out_data;

  char_lcd_4bit_interface uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sequencer forecast state and timing registers
  logic [4:0]                   lcd_phase = lcd4_pkg::PH_IDLE;
  logic [lcd4_pkg::LONG_W-1:0]  lcd_wait = '0;
  logic [7:0]                   lcd_byte = '0;
  logic                         lcd_pause = 1'b0;
  logic                         lcd_rs = 1'b0;
  logic                         lcd_en = 1'b0;
  logic [3:0]                   lcd_nib = '0;
  logic [lcd4_pkg::SHORT_W-1:0] gap_us = lcd4_pkg::NIBBLE_GAP_RST;
  logic [lcd4_pkg::SHORT_W-1:0] wpause_us = lcd4_pkg::WRITE_PAUSE_RST;
  logic [lcd4_pkg::LONG_W-1:0]  cpause_us = lcd4_pkg::CHAR_PAUSE_RST;
  logic [lcd4_pkg::LONG_W-1:0]  pwait_us = lcd4_pkg::POWER_WAIT_RST;
  logic [lcd4_pkg::LONG_W-1:0]  idone_us = lcd4_pkg::INIT_DONE_RST;

  lcd4_pkg::out_item_t pin_forecast[$];
  int        errors = 0;
  int        results_seen = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  function automatic logic [lcd4_pkg::LONG_W-1:0] phase_length(input logic [4:0] p);
    case (p)
      lcd4_pkg::PH_PWAIT: return pwait_us;
      lcd4_pkg::PH_W5000: return lcd4_pkg::WAIT_5000;
      lcd4_pkg::PH_W100: return lcd4_pkg::WAIT_100;
      lcd4_pkg::PH_W50A, lcd4_pkg::PH_W50B: return lcd4_pkg::WAIT_50;
      lcd4_pkg::PH_PDONE: return idone_us;
      lcd4_pkg::PH_N1_GAP, lcd4_pkg::PH_N2_GAP, lcd4_pkg::PH_N3_GAP, lcd4_pkg::PH_N4_GAP,
      lcd4_pkg::PH_HI_GAP, lcd4_pkg::PH_LO_GAP:
        return {8'd0, gap_us};
      lcd4_pkg::PH_CHARP: return lcd_pause ? cpause_us : '0;
      lcd4_pkg::PH_WRITEP: return {8'd0, wpause_us};
      default: return lcd4_pkg::WAIT_ONE;
    endcase
  endfunction

  function automatic logic [4:0] phase_after(input logic [4:0] p);
    if (p == lcd4_pkg::PH_PDONE || p >= lcd4_pkg::PH_WRITEP) return lcd4_pkg::PH_IDLE;
    return p + 5'd1;
  endfunction

  // Enter a phase; zero-length phases fall through to the next one
  task automatic begin_phase(input logic [4:0] start);
    logic [4:0]                  p;
    logic [lcd4_pkg::LONG_W-1:0] len;
    int                          k;
    p = start;
    for (k = 0; k < 28; k++) begin
      lcd_phase = p;
      if (p == lcd4_pkg::PH_IDLE || p > lcd4_pkg::PH_WRITEP) begin
        lcd_phase = lcd4_pkg::PH_IDLE;
        lcd_wait = '0;
        lcd_en = 1'b0;
        return;
      end
      case (p)
        lcd4_pkg::PH_N1_EN, lcd4_pkg::PH_N2_EN, lcd4_pkg::PH_N3_EN, lcd4_pkg::PH_N4_EN,
        lcd4_pkg::PH_HI_EN, lcd4_pkg::PH_LO_EN: lcd_en = 1'b1;
        default: lcd_en = 1'b0;
      endcase
      case (p)
        lcd4_pkg::PH_N1_SET, lcd4_pkg::PH_N2_SET,
        lcd4_pkg::PH_N3_SET: lcd_nib = lcd4_pkg::NIB_THREE;
        lcd4_pkg::PH_N4_SET: lcd_nib = lcd4_pkg::NIB_TWO;
        lcd4_pkg::PH_HI_SET: lcd_nib = lcd_byte[7:4];
        lcd4_pkg::PH_LO_SET: lcd_nib = lcd_byte[3:0];
        default: ;
      endcase
      if (p == lcd4_pkg::PH_CHARP) lcd_rs = 1'b0;
      len = phase_length(p);
      if (len != '0) begin
        lcd_wait = len;
        return;
      end
      p = phase_after(p);
    end
    lcd_phase = lcd4_pkg::PH_IDLE;
    lcd_wait = '0;
  endtask

  task automatic forecast_pins(input lcd4_pkg::in_item_t it, output lcd4_pkg::out_item_t res);
    logic rej;
    rej = 1'b0;
    if (it.op == lcd4_pkg::OP_TICK) begin
      if (lcd_phase != lcd4_pkg::PH_IDLE) begin
        if (lcd_wait != '0) lcd_wait = lcd_wait - 1'b1;
        if (lcd_wait == '0) begin_phase(phase_after(lcd_phase));
      end
    end else if (lcd_phase != lcd4_pkg::PH_IDLE) begin
      rej = 1'b1;
    end else if (it.op == lcd4_pkg::OP_INIT) begin
      lcd_rs = 1'b0;
      lcd_en = 1'b0;
      lcd_nib = '0;
      lcd_pause = 1'b0;
      begin_phase(lcd4_pkg::PH_PWAIT);
    end else begin
      lcd_byte = it.value;
      lcd_rs = (it.op == lcd4_pkg::OP_DATA);
      lcd_pause = (it.op == lcd4_pkg::OP_DATA) && it.long_pause;
      begin_phase(lcd4_pkg::PH_HI_SET);
    end
    res.rs_level = lcd_rs;
    res.en_level = lcd_en;
    res.bus_nibble = lcd_nib;
    res.busy_res = (lcd_phase != lcd4_pkg::PH_IDLE);
    res.rejected = rej;
  endtask

  function automatic lcd4_pkg::in_item_t make_item(input logic [1:0] op, input logic [7:0] v,
                                                   input logic lp);
    lcd4_pkg::in_item_t it;
    it.op = op;
    it.value = v;
    it.long_pause = lp;
    return it;
  endfunction

  function automatic lcd4_pkg::in_item_t rand_item(input logic [1:0] op);
    return make_item(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endfunction

  function automatic logic [1:0] rand_request_op();
    return 2'($urandom_range(1, 3));
  endfunction

  function automatic cfg_word_t rand_word(input int unsigned hi);
    return cfg_word_t'($urandom_range(hi));
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_pins
    lcd4_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pin_forecast.size() == 0) begin
        flag($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        want = pin_forecast.pop_front();
        if (out_data !== want)
          flag($sformatf("result %0d rs/en/nib/busy/rej: got %b/%b/%h/%b/%b, want %b/%b/%h/%b/%b",
                         results_seen, out_data.rs_level, out_data.en_level,
                         out_data.bus_nibble, out_data.busy_res, out_data.rejected,
                         want.rs_level, want.en_level, want.bus_nibble, want.busy_res,
                         want.rejected));
      end
    end
  end

  // Hold the request until accepted, then forecast its pins
  task automatic push_request(input lcd4_pkg::in_item_t it);
    lcd4_pkg::out_item_t res;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    forecast_pins(it, res);
    pin_forecast.push_back(res);
  endtask

  task automatic tick_us();
    push_request(rand_item(lcd4_pkg::OP_TICK));
  endtask

  task automatic poke_busy();
    push_request(rand_item(rand_request_op()));
  endtask

  task automatic run_until_idle(input int noise_pct);
    while (lcd_phase != lcd4_pkg::PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) poke_busy();
      else tick_us();
    end
  endtask

  task automatic set_register(input cfg_idx_t idx, input cfg_word_t val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_forecast.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcd4_pkg::CFG_NIBBLE_GAP: gap_us = val[lcd4_pkg::SHORT_W-1:0];
      lcd4_pkg::CFG_WRITE_PAUSE: wpause_us = val[lcd4_pkg::SHORT_W-1:0];
      lcd4_pkg::CFG_CHAR_PAUSE: cpause_us = val;
      lcd4_pkg::CFG_POWER_WAIT: pwait_us = val;
      lcd4_pkg::CFG_INIT_DONE: idone_us = val;
      default: ;
    endcase
  endtask

  task automatic load_timing(input cfg_word_t gap, input cfg_word_t wp,
                             input cfg_word_t cp, input cfg_word_t pw,
                             input cfg_word_t idn);
    set_register(lcd4_pkg::CFG_NIBBLE_GAP, gap);
    set_register(lcd4_pkg::CFG_WRITE_PAUSE, wp);
    set_register(lcd4_pkg::CFG_CHAR_PAUSE, cp);
    set_register(lcd4_pkg::CFG_POWER_WAIT, pw);
    set_register(lcd4_pkg::CFG_INIT_DONE, idn);
  endtask

  // Reset timing: idle ticks, command with long-pause flag, data byte, requests while busy
  task automatic test_reset_timing();
    tick_us();
    tick_us();
    push_request(make_item(lcd4_pkg::OP_CMD, 8'hFF, 1'b1));
    push_request(make_item(lcd4_pkg::OP_CMD, 8'h12, 1'b0));
    push_request(make_item(lcd4_pkg::OP_DATA, 8'h34, 1'b1));
    push_request(make_item(lcd4_pkg::OP_INIT, 8'h00, 1'b0));
    run_until_idle(3);
    push_request(make_item(lcd4_pkg::OP_DATA, 8'h00, 1'b0));
    run_until_idle(3);
  endtask

  // All timing registers zero; init must clear the pins a data byte left behind
  task automatic test_zero_waits();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    load_timing(18'h3FC00, '0, '0, '0, '0);
    push_request(make_item(lcd4_pkg::OP_DATA, 8'hA5, 1'b1));
    run_until_idle(5);
    push_request(make_item(lcd4_pkg::OP_CMD, 8'h5A, 1'b0));
    run_until_idle(5);
    push_request(make_item(lcd4_pkg::OP_DATA, 8'hFF, 1'b0));
    run_until_idle(0);
    push_request(make_item(lcd4_pkg::OP_INIT, 8'hFF, 1'b1));
    run_until_idle(2);
    tick_us();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_register_index();
    cfg_idx_t idx;
    load_timing(18'd3, 18'd2, 18'd5, 18'd4, 18'd6);
    for (idx = cfg_idx_t'(lcd4_pkg::CFG_INIT_DONE + 1); idx != '0; idx++)
      set_register(idx, rand_word(262143));
    push_request(make_item(lcd4_pkg::OP_DATA, 8'hC3, 1'b1));
    run_until_idle(5);
  endtask

  // Rewrite timing while a byte is still going out
  task automatic test_write_mid_sequence();
    load_timing(18'd2, 18'd3, 18'd4, 18'd1, 18'd1);
    push_request(make_item(lcd4_pkg::OP_DATA, 8'h96, 1'b1));
    repeat (3) tick_us();
    set_register(lcd4_pkg::CFG_NIBBLE_GAP, 18'd6);
    set_register(lcd4_pkg::CFG_CHAR_PAUSE, 18'd9);
    set_register(lcd4_pkg::CFG_WRITE_PAUSE, 18'd1);
    run_until_idle(5);
  endtask

  task automatic random_traffic(input int budget);
    int                 sent;
    int                 inits;
    int                 roll;
    logic               in_powerup;
    lcd4_pkg::in_item_t it;
    sent = 0;
    inits = 0;
    while (sent < budget) begin
      in_powerup = (lcd_phase != lcd4_pkg::PH_IDLE) && (lcd_phase <= lcd4_pkg::PH_PDONE);
      roll = $urandom_range(99);
      if (lcd_phase == lcd4_pkg::PH_IDLE) begin
        if (roll < 6) it = rand_item(lcd4_pkg::OP_TICK);
        else if (roll < 12 && inits == 0) begin
          it = rand_item(lcd4_pkg::OP_INIT);
          inits++;
        end else if (roll < 56) it = rand_item(lcd4_pkg::OP_CMD);
        else it = rand_item(lcd4_pkg::OP_DATA);
      end else if (roll < 7) begin
        it = rand_item(rand_request_op());
      end else begin
        it = rand_item(lcd4_pkg::OP_TICK);
      end
      push_request(it);
      if (!(in_powerup && it.op == lcd4_pkg::OP_TICK)) sent++;
    end
    run_until_idle(5);
  endtask

  task automatic test_random_traffic();
    int i;
    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 54; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 54; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (i == 1) load_timing('0, '0, '0, '0, '0);
      else if (i == 2)
        load_timing(rand_word(12), rand_word(12), rand_word(40),
                    rand_word(60), rand_word(60));
      else
        load_timing(rand_word(7), rand_word(7), rand_word(15),
                    rand_word(31), rand_word(31));
      random_traffic(115);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Largest timing values; the run ends partway into the long character pause
  task automatic test_upper_limits();
    load_timing(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    push_request(make_item(lcd4_pkg::OP_CMD, 8'hC3, 1'b1));
    run_until_idle(1);
    push_request(make_item(lcd4_pkg::OP_DATA, 8'h3C, 1'b1));
    while (lcd_phase != lcd4_pkg::PH_CHARP) tick_us();
    repeat (300) begin
      if ($urandom_range(99) < 5) poke_busy();
      else tick_us();
    end
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_flow
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_timing();
    test_zero_waits();
    test_register_index();
    test_write_mid_sequence();
    test_random_traffic();
    test_upper_limits();
    @(negedge clk);
    in_valid <= 1'b0;
    for (k = 0; k < 500 && pin_forecast.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pin_forecast.size() != 0)
      flag($sformatf("%0d results never arrived", pin_forecast.size()));
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
